### rtl/ottc_pkg.sv
// Shared types and result codes for the one-time token checker.
// No dependencies; the top level refers to these by scoped names.
`default_nettype none

package ottc_pkg;

    localparam int TOKEN_W  = 32;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [TOKEN_W-1:0]  token_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    localparam status_t STATUS_ACCEPTED = 2'd0;
    localparam status_t STATUS_USED     = 2'd1;
    localparam status_t STATUS_UNKNOWN  = 2'd2;
    localparam status_t STATUS_LOADED   = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

endpackage

`default_nettype wire

### rtl/one_time_token_checker.sv
// One-time token checker: load a token slot, or check a presented token by walking
// the table in index order through a single 32-bit comparator; uses ottc_pkg.
// Load: out_valid rises at the accepting edge.
// Check: out_valid rises once the walk finds the first match, or once the last slot has
//   been compared without one; one compare per cycle, next request taken with the result.
// Reset: a clearing pass marks every slot absent and unused first.
`default_nettype none

module one_time_token_checker #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire                        command,
    input  wire  [ottc_pkg::SLOT_W-1:0]  entry_index,
    input  wire  [ottc_pkg::TOKEN_W-1:0] token,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [ottc_pkg::STATUS_W-1:0] status,
    output logic [ottc_pkg::SLOT_W-1:0]   matched_index
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;

    // Table storage
    ottc_pkg::token_t token_mem   [TABLE_ENTRIES];
    logic             present_mem [TABLE_ENTRIES];
    logic             unused_mem  [TABLE_ENTRIES];

    ottc_pkg::token_t tok_rd_reg;
    logic             pres_rd_reg;
    logic             unused_rd_reg;

    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg;
    ottc_pkg::token_t check_tok_reg;

    logic                 out_valid_reg;
    ottc_pkg::status_t    status_reg;
    ottc_pkg::slot_t      matched_reg;

    logic             accept;
    logic             load_ok;
    logic [31:0]      slot_ext;
    logic [IDX_W-1:0] load_addr;
    logic             hit;
    logic [31:0]      cmp_idx_ext;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign slot_ext  = 32'(entry_index);
    assign load_ok   = slot_ext < 32'(TABLE_ENTRIES);
    assign load_addr = slot_ext[IDX_W-1:0];

    assign cmp_idx_ext = 32'(cmp_idx_reg);

    // The shared comparator: one table entry per cycle against the held token
    assign hit = cmp_valid_reg && pres_rd_reg && (tok_rd_reg == check_tok_reg);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign matched_index = matched_reg;

    // Token table: written by load, read at the scan address
    always_ff @(posedge clk)
    begin
        if (accept && command == ottc_pkg::CMD_LOAD && load_ok)
        begin
            token_mem[load_addr] <= token;
        end
        tok_rd_reg <= token_mem[scan_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            present_mem[clr_addr_reg] <= 1'b0;
        end
        else if (accept && command == ottc_pkg::CMD_LOAD && load_ok)
        begin
            present_mem[load_addr] <= 1'b1;
        end
        pres_rd_reg <= present_mem[scan_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            unused_mem[clr_addr_reg] <= 1'b1;
        end
        else if (state_reg == ST_SCAN && hit && unused_rd_reg)
        begin
            unused_mem[cmp_idx_reg] <= 1'b0;
        end
        unused_rd_reg <= unused_mem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ottc_pkg::STATUS_UNKNOWN;
            matched_reg   <= '0;
            check_tok_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (command == ottc_pkg::CMD_LOAD)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= ottc_pkg::STATUS_LOADED;
                            matched_reg   <= entry_index;
                        end
                        else
                        begin
                            check_tok_reg <= token;
                            scan_addr_reg <= '0;
                            cmp_valid_reg <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (hit)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= unused_rd_reg ? ottc_pkg::STATUS_ACCEPTED
                                                       : ottc_pkg::STATUS_USED;
                        matched_reg   <= cmp_idx_ext[ottc_pkg::SLOT_W-1:0];
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else if (cmp_valid_reg && cmp_idx_reg == LAST_IDX)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ottc_pkg::STATUS_UNKNOWN;
                        matched_reg   <= '0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        // advance: compare the entry just read, issue the next read
                        cmp_idx_reg   <= scan_addr_reg;
                        cmp_valid_reg <= 1'b1;
                        if (scan_addr_reg != LAST_IDX)
                        begin
                            scan_addr_reg <= scan_addr_reg + 1'b1;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The output register is free for the whole walk
    a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !out_valid_reg)
        else $error("result pending during table walk");

    // Without a match the walk steps one entry per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_valid_reg && !hit && cmp_idx_reg != LAST_IDX)
        |=> (cmp_idx_reg == $past(cmp_idx_reg) + 1'b1))
        else $error("table walk skipped or repeated an entry");

    // A check never reports a load
    a_check_status: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && $past(state_reg == ST_SCAN))
        |-> status_reg != ottc_pkg::STATUS_LOADED)
        else $error("check finished with load status");

    // No request is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready && !out_valid_reg)
        else $error("request handled before table clear finished");

endmodule

`default_nettype wire

### tb/sv/token_check_sb_pkg.sv
// Scoreboard for the one-time token checker: predicts the status and slot of
// every request from its own copy of the token table and checks the results.
// Depends on ottc_pkg for the field types and status/command codes.
package token_check_sb_pkg;

    import ottc_pkg::*;

    localparam int TABLE_ENTRIES = 1024;

    typedef struct packed {
        status_t status;
        slot_t   index;
    } verdict_t;

    class token_check_scoreboard;

        token_t   slot_token [TABLE_ENTRIES];
        bit       slot_present [TABLE_ENTRIES];
        bit       slot_unused [TABLE_ENTRIES];
        verdict_t expected_verdicts [$];
        int       mismatches;
        int       status_count [4];

        function new();
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                slot_token[k]   = '0;
                slot_present[k] = 1'b0;
                slot_unused[k]  = 1'b1;
            end
            mismatches = 0;
            foreach (status_count[s])
                status_count[s] = 0;
        endfunction

        // Predict the result of one accepted request and queue it.
        function void note_request(logic cmd, slot_t idx, token_t tok);
            verdict_t v;
            int       k;
            v.status = STATUS_UNKNOWN;
            v.index  = '0;
            if (cmd == CMD_LOAD)
            begin
                // reload keeps the unused mark as it is
                if (idx < TABLE_ENTRIES)
                begin
                    slot_token[idx]   = tok;
                    slot_present[idx] = 1'b1;
                end
                v.status = STATUS_LOADED;
                v.index  = idx;
            end
            else
            begin
                // lowest present match decides; later duplicates are never consulted
                k = 0;
                while (k < TABLE_ENTRIES && !(slot_present[k] && slot_token[k] == tok))
                    k++;
                if (k < TABLE_ENTRIES)
                begin
                    v.status       = slot_unused[k] ? STATUS_ACCEPTED : STATUS_USED;
                    v.index        = slot_t'(k);
                    slot_unused[k] = 1'b0;
                end
            end
            status_count[v.status]++;
            expected_verdicts.push_back(v);
        endfunction

        function void check_result(status_t st, slot_t idx);
            verdict_t v;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: status=%0d index=%0d",
                             st, idx);
            end
            else
            begin
                v = expected_verdicts.pop_front();
                if (st !== v.status || idx !== v.index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: status exp %0d got %0d, index exp %0d got %0d",
                                 v.status, st, v.index, idx);
                end
            end
        endfunction

        function int outstanding();
            return expected_verdicts.size();
        endfunction

    endclass

endpackage

### tb/sv/tb.sv
// Top-level bench for one_time_token_checker: directed and random load/check
// requests with random idling on both handshakes, checked by the scoreboard.
// Depends on ottc_pkg, token_check_sb_pkg and the RTL top level.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ottc_pkg::*;
    import token_check_sb_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 8;
    localparam int RANDOM_ITEMS   = 560;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    logic    command = CMD_LOAD;
    slot_t   entry_index = '0;
    token_t  token = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    status_t status;
    slot_t   matched_index;

    token_check_scoreboard sb;

    bit no_idle = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int results_seen = 0;
    int results_taken = 0;

    one_time_token_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .entry_index(entry_index),
        .token(token),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .matched_index(matched_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(status, matched_index);
                results_seen++;
            end
            if (in_valid && in_ready)
                sb.note_request(command, entry_index, token);
        end
    end

    // Result side: random stall before each result, plus long hold-offs on demand.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (results_taken != results_seen)
            begin
                results_taken = results_seen;
                stall_left    = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic cmd, input slot_t idx, input token_t tok);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        token       <= tok;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_slot(input slot_t idx, input token_t tok);
        send_request(CMD_LOAD, idx, tok);
    endtask

    task automatic check_token(input token_t tok);
        send_request(CMD_CHECK, slot_t'($urandom_range(0, 1023)), tok);
    endtask

    // Hold the request side off until every pending result has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic run_directed();
        check_token(32'h0000_0000);             // empty table: unknown
        load_slot(10'd0, 32'h0000_0000);
        load_slot(10'd1023, 32'hFFFF_FFFF);
        check_token(32'h0000_0000);             // accepted
        check_token(32'h0000_0000);             // used
        check_token(32'hFFFF_FFFF);             // full walk to the last slot
        check_token(32'hFFFF_FFFF);
        load_slot(10'd5, 32'hA5A5_A5A5);
        load_slot(10'd700, 32'hA5A5_A5A5);      // duplicate behind slot 5
        check_token(32'hA5A5_A5A5);
        check_token(32'hA5A5_A5A5);             // still slot 5, now used
        load_slot(10'd5, 32'h5A5A_5A5A);        // reload keeps the used mark
        check_token(32'h5A5A_5A5A);
        check_token(32'hA5A5_A5A5);             // now falls through to slot 700
        load_slot(10'd3, 32'h1234_5678);
        check_token(32'h1234_5678);
        check_token(32'hDEAD_BEEF);
        load_slot(10'd512, 32'h8000_0000);
        load_slot(10'h155, 32'h5555_5555);
        load_slot(10'h2AA, 32'hAAAA_AAAA);
        check_token(32'h5555_5555);
        check_token(32'hAAAA_AAAA);
        check_token(32'h8000_0000);
        wait_for_drain();
    endtask

    task automatic run_random(input int count);
        token_t loaded_tokens [$];
        token_t last_checked;
        token_t tok;
        slot_t  idx;
        int     pick;
        last_checked = 32'h0;
        for (int n = 0; n < count; n++)
        begin
            no_idle = ((n / 60) % 3 == 1);
            if (n == 150 || n == 450)
                hold_requests++;
            if (n == 320)
                wait_for_drain();
            pick = $urandom_range(0, 99);
            if (pick < 40 || loaded_tokens.size() == 0)
            begin
                // bias some loads to low slots so checks find them quickly
                if ($urandom_range(0, 3) == 0)
                    idx = slot_t'($urandom_range(0, 31));
                else
                    idx = slot_t'($urandom_range(0, 1023));
                if (loaded_tokens.size() != 0 && $urandom_range(0, 9) == 0)
                    tok = loaded_tokens[$urandom_range(0, loaded_tokens.size() - 1)];
                else
                begin
                    tok = $urandom;
                    loaded_tokens.push_back(tok);
                end
                load_slot(idx, tok);
            end
            else
            begin
                if (pick < 75)
                    tok = loaded_tokens[$urandom_range(0, loaded_tokens.size() - 1)];
                else if (pick < 88)
                    tok = last_checked;
                else
                    tok = $urandom;
                last_checked = tok;
                check_token(tok);
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d loads, %0d accepted, %0d reused, %0d unknown",
                 sb.status_count[STATUS_LOADED] + sb.status_count[STATUS_ACCEPTED]
                 + sb.status_count[STATUS_USED] + sb.status_count[STATUS_UNKNOWN],
                 sb.status_count[STATUS_LOADED], sb.status_count[STATUS_ACCEPTED],
                 sb.status_count[STATUS_USED], sb.status_count[STATUS_UNKNOWN]);
        $display("Mismatches: %0d, still pending: %0d", sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
